// File: src/bsst_pkg.sv
// Package for the bounded set span tracker: shared types, codes and constants.
// Used by bsst_cell, bsst_gap_reduce and bounded_set_span_tracker_core; depends on nothing.
package bsst_pkg;

	localparam int VAL_W   = 32;
	localparam int CAP_W   = 11;
	localparam int ADDR_W  = 2;
	localparam int DATA_W  = 32;
	localparam int GROUP_W = 32;

	localparam logic [ADDR_W-1:0] REG_CAPACITY = 2'd0;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_TOO_FEW = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_MERGE
	} state_t;

	// What one cell hands to its right-hand neighbour.
	typedef struct packed {
		logic             gt;
		logic             occ;
		logic [VAL_W-1:0] val;
	} link_t;

	// Gap candidates found at the insertion point (zero elsewhere).
	typedef struct packed {
		logic [VAL_W-1:0] lo;
		logic [VAL_W-1:0] hi;
	} cand_t;

endpackage

// File: src/bounded_set_span_tracker_core.sv
// Top level of the bounded set span tracker: cell chain, candidate reduction, control.
// Depends on bsst_pkg, bsst_cell and bsst_gap_reduce.
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  ------------------------------------
//  input     in         in_valid / in_stall          cmd, value
//  result    out        out_valid / out_stall        status, shortest_gap, longest_gap
//  config    in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// A query or a refused add is complete at the accepting edge; a stored add also needs a merge:
// the chain shifts at the accepting edge and the registered candidate tree is merged into the
// least gap in the next cycle, during which no transfer is taken. Reset clears the count,
// the least gap and the control state; the cells need no clearing pass, since only occupied
// cells are ever compared or reported. A result waits in the output register while
// out_stall is high, and no input transfer is taken until that register can be refilled.
module bounded_set_span_tracker_core #(
	parameter int STORE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic signed [bsst_pkg::VAL_W-1:0] value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [bsst_pkg::VAL_W-1:0]    shortest_gap,
	output logic [bsst_pkg::VAL_W-1:0]    longest_gap,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bsst_pkg::ADDR_W-1:0]   paddr,
	input  logic [bsst_pkg::DATA_W-1:0]   pwdata,
	output logic [bsst_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > bsst_pkg::CAP_W) ? CNT_W : bsst_pkg::CAP_W;

	// Control and architectural state.
	bsst_pkg::state_t              state_q, state_d;
	logic [CNT_W-1:0]              count_q;
	logic [bsst_pkg::VAL_W-1:0]    least_gap_q;
	logic [bsst_pkg::CAP_W-1:0]    capacity_q;
	// Running extremes of the held values, in biased form.
	logic [bsst_pkg::VAL_W-1:0]    min_q;
	logic [bsst_pkg::VAL_W-1:0]    max_q;
	// Output register.
	logic                          out_valid_q;
	logic [1:0]                    status_q;
	logic [bsst_pkg::VAL_W-1:0]    shortest_q;
	logic [bsst_pkg::VAL_W-1:0]    longest_q;

	logic                          in_acc;
	logic                          out_free;
	logic                          merge_en;
	logic                          full;
	logic                          insert;
	logic [bsst_pkg::VAL_W-1:0]    biased;
	logic                          cfg_wr;

	bsst_pkg::link_t               link  [STORE_DEPTH];
	bsst_pkg::link_t               first_left;
	bsst_pkg::cand_t               cand  [STORE_DEPTH];
	logic [STORE_DEPTH-1:0]        occ;
	bsst_pkg::cand_t               merged;
	logic [bsst_pkg::VAL_W-1:0]    gap_cand;

	// Flipping the sign bit makes unsigned order equal to signed order, and the
	// unsigned difference of two biased values is the exact distance between them.
	assign biased = {~value[bsst_pkg::VAL_W-1], value[bsst_pkg::VAL_W-2:0]};

	// Configuration register. pready is tied high, so every access completes at once.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == bsst_pkg::REG_CAPACITY)
		? bsst_pkg::DATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (cfg_wr && paddr == bsst_pkg::REG_CAPACITY) begin
			capacity_q <= pwdata[bsst_pkg::CAP_W-1:0];
		end
	end

	// The effective limit is the smaller of the capacity register and the store depth.
	assign full = (CMP_W'(count_q) >= CMP_W'(capacity_q))
		|| (count_q == CNT_W'(STORE_DEPTH));

	// Handshake: the output register may be refilled when empty or being emptied.
	assign out_free = !out_valid_q || !out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign insert   = in_acc && (cmd == bsst_pkg::CMD_ADD) && !full;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsst_pkg::S_IDLE: begin
				if (insert) begin
					state_d = bsst_pkg::S_MERGE;
				end
			end
			bsst_pkg::S_MERGE: begin
				state_d = bsst_pkg::S_IDLE;
			end
			default: begin
				state_d = bsst_pkg::S_IDLE;
			end
		endcase
	end

	// Output decode of the state machine.
	always_comb begin
		in_stall = 1'b1;
		merge_en = 1'b0;
		unique case (state_q)
			bsst_pkg::S_IDLE: begin
				in_stall = !out_free;
			end
			bsst_pkg::S_MERGE: begin
				merge_en = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The chain of cells. Occupancy is a prefix of the chain given by the count, and
	// the first cell sees a left neighbour that is empty and never greater.
	assign first_left = '0;

	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		assign occ[i] = count_q > CNT_W'(i);

		bsst_cell u_cell (
			.clk      (clk),
			.shift_en (insert),
			.new_val  (biased),
			.occ      (occ[i]),
			.left     ((i == 0) ? first_left : link[(i == 0) ? 0 : i - 1]),
			.right    (link[i]),
			.cand     (cand[i])
		);
	end

	// Only the insertion cell offers candidates; they are gathered while the chain shifts.
	bsst_gap_reduce #(
		.DEPTH (STORE_DEPTH)
	) u_gap_reduce (
		.clk    (clk),
		.load   (insert),
		.cand   (cand),
		.merged (merged)
	);

	assign gap_cand = (merged.lo < merged.hi) ? merged.lo : merged.hi;

	// Count and least gap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			least_gap_q <= '1;
		end else begin
			if (insert) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (merge_en && gap_cand < least_gap_q) begin
				least_gap_q <= gap_cand;
			end
		end
	end

	// The extremes are only read once two values are held, so they need no reset.
	always_ff @(posedge clk) begin
		if (insert) begin
			if (count_q == '0 || biased < min_q) begin
				min_q <= biased;
			end
			if (count_q == '0 || biased > max_q) begin
				max_q <= biased;
			end
		end
	end

	// Output register. An add always reports zero gaps, so its result is ready at once;
	// a query reads the least gap, which is settled whenever the block is idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q   <= bsst_pkg::STATUS_OK;
			shortest_q <= '0;
			longest_q  <= '0;
			if (cmd == bsst_pkg::CMD_ADD) begin
				if (full) begin
					status_q <= bsst_pkg::STATUS_FULL;
				end
			end else if (count_q < CNT_W'(2)) begin
				status_q <= bsst_pkg::STATUS_TOO_FEW;
			end else begin
				shortest_q <= least_gap_q;
				longest_q  <= max_q - min_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign shortest_gap = shortest_q;
	assign longest_gap  = longest_q;

	// The count never passes the depth of the chain.
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STORE_DEPTH))
		else $error("held count beyond store depth");

	// A stored add grows the set by exactly one.
	a_count_step : assert property (@(posedge clk) disable iff (!arst_n)
		insert |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("held count did not step on insert");

	// The least gap can only shrink between resets.
	a_gap_monotone : assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> least_gap_q <= $past(least_gap_q))
		else $error("least gap grew");

	// No transfer is taken while a merge is pending.
	a_merge_blocks : assert property (@(posedge clk) disable iff (!arst_n)
		insert |=> !in_acc)
		else $error("transfer accepted during merge");

	// With two or more values held the extremes are ordered.
	a_extremes : assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> max_q >= min_q)
		else $error("maximum below minimum");

endmodule

// File: src/bsst_cell.sv
// One cell of the sorted value chain: holds one biased value and shifts on insert.
// Depends on bsst_pkg.
module bsst_cell (
	input  logic                      clk,
	input  logic                      shift_en,
	input  logic [bsst_pkg::VAL_W-1:0] new_val,
	input  logic                      occ,
	input  bsst_pkg::link_t           left,
	output bsst_pkg::link_t           right,
	output bsst_pkg::cand_t           cand
);

	logic [bsst_pkg::VAL_W-1:0] val_q;
	logic                       gt;
	logic                       pos;
	logic [bsst_pkg::VAL_W-1:0] lo;
	logic [bsst_pkg::VAL_W-1:0] hi;

	// An empty cell counts as greater, so the insertion point is always found.
	assign gt  = !occ || (val_q > new_val);
	assign pos = gt && !left.gt;
	assign lo  = left.occ ? (new_val - left.val) : '1;
	assign hi  = occ ? (val_q - new_val) : '1;

	always_comb begin
		cand = '0;
		if (pos) begin
			cand.lo = lo;
			cand.hi = hi;
		end
	end

	assign right.gt  = gt;
	assign right.occ = occ;
	assign right.val = val_q;

	always_ff @(posedge clk) begin
		if (shift_en && gt) begin
			val_q <= left.gt ? left.val : new_val;
		end
	end

endmodule

// File: src/bsst_gap_reduce.sv
// Registered two-level OR tree that gathers the one-hot gap candidates of the chain.
// Depends on bsst_pkg.
module bsst_gap_reduce #(
	parameter int DEPTH = 1024
) (
	input  logic            clk,
	input  logic            load,
	input  bsst_pkg::cand_t cand [DEPTH],
	output bsst_pkg::cand_t merged
);

	localparam int NG = (DEPTH + bsst_pkg::GROUP_W - 1) / bsst_pkg::GROUP_W;

	bsst_pkg::cand_t grp_d  [NG];
	bsst_pkg::cand_t grp_s1 [NG];

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < bsst_pkg::GROUP_W; k++) begin
				if (g * bsst_pkg::GROUP_W + k < DEPTH) begin
					grp_d[g] = bsst_pkg::cand_t'(grp_d[g] | cand[g * bsst_pkg::GROUP_W + k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int g = 0; g < NG; g++) begin
				grp_s1[g] <= grp_d[g];
			end
		end
	end

	always_comb begin
		merged = '0;
		for (int g = 0; g < NG; g++) begin
			merged = bsst_pkg::cand_t'(merged | grp_s1[g]);
		end
	end

endmodule

// File: test/bounded_set_span_tracker_core_test.sv
// Self-checking testbench for bounded_set_span_tracker_core: random and directed add and query
// transfers, checked against an in-bench model of the sorted set. Depends on bsst_pkg and the RTL.
module bounded_set_span_tracker_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH   = 1024;
	localparam int CLK_HALF      = 10;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 50;
	localparam int HOLD_AT       = 400;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE        = 8;
	localparam int CAP_MAX       = 2047;
	localparam longint TIMEOUT_NS = 64'd8_000_000;

	localparam logic [bsst_pkg::VAL_W-1:0] SIGN_BIT = 32'h8000_0000;
	localparam logic [bsst_pkg::VAL_W-1:0] VAL_MIN  = 32'h8000_0000;
	localparam logic [bsst_pkg::VAL_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;

	typedef struct packed {
		logic                       op;
		logic [bsst_pkg::VAL_W-1:0] val;
	} span_item_t;

	typedef struct packed {
		logic [1:0]                 status;
		logic [bsst_pkg::VAL_W-1:0] shortest;
		logic [bsst_pkg::VAL_W-1:0] longest;
	} span_result_t;

	// Receiver behaviour, chosen afresh for each stretch of cycles.
	typedef enum logic [1:0] {
		RX_FLOW,
		RX_HALF,
		RX_LIGHT,
		RX_HEAVY
	} rx_mode_t;

	logic                                clk;
	logic                                arst_n   = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic                                cmd      = bsst_pkg::CMD_ADD;
	logic signed [bsst_pkg::VAL_W-1:0]   value    = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic [1:0]                          status;
	logic [bsst_pkg::VAL_W-1:0]          shortest_gap;
	logic [bsst_pkg::VAL_W-1:0]          longest_gap;
	logic                                psel    = 1'b0;
	logic                                penable = 1'b0;
	logic                                pwrite  = 1'b0;
	logic [bsst_pkg::ADDR_W-1:0]         paddr   = bsst_pkg::REG_CAPACITY;
	logic [bsst_pkg::DATA_W-1:0]         pwdata  = '0;
	logic [bsst_pkg::DATA_W-1:0]         prdata;
	logic                                pready;

	bounded_set_span_tracker_core #(
		.STORE_DEPTH(STORE_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.shortest_gap(shortest_gap),
		.longest_gap (longest_gap),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// Shadow of the set. Values are kept with the sign bit flipped, so that an unsigned
	// comparison gives the signed order and a plain subtraction gives the exact gap.
	logic [bsst_pkg::VAL_W-1:0] sorted_biased [STORE_DEPTH];
	int                         held       = 0;
	logic [bsst_pkg::VAL_W-1:0] least_gap  = '1;
	logic [bsst_pkg::CAP_W-1:0] cap_shadow = '0;

	span_result_t     span_expect_q [$];
	span_item_t       pending_q [$];

	int                         issued      = 0;
	int                         accepted    = 0;
	int                         error_count = 0;
	logic [bsst_pkg::VAL_W-1:0] recent_val  = '0;

	int               gap_left   = 0;
	int               burst_left = 0;

	rx_mode_t         rx_mode   = RX_FLOW;
	int               mode_left = 0;
	int               hold_left = 0;
	bit               hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Generous overall limit; a correct run needs only a small fraction of it.
	initial begin
		#(TIMEOUT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	// Only the first ten problems are printed in full; the rest are just counted.
	task automatic note_error(input string msg);
		if (error_count < 10)
			$display("MISMATCH: %s", msg);
		error_count++;
	endtask

	// Works out the result of one accepted transfer and files it as the next expected result.
	// The set only ever grows, and the least gap only ever shrinks, because the block is
	// reset just once.
	task automatic predict_span_result(input span_item_t it);
		span_result_t               r;
		int                         limit;
		int                         pos;
		int                         k;
		logic [bsst_pkg::VAL_W-1:0] b;
		logic [bsst_pkg::VAL_W-1:0] d;
		r = '0;
		r.status = bsst_pkg::STATUS_OK;
		if (it.op == bsst_pkg::CMD_ADD) begin
			limit = (int'(cap_shadow) < STORE_DEPTH) ? int'(cap_shadow) : STORE_DEPTH;
			if (held < limit) begin
				b = it.val ^ SIGN_BIT;
				pos = 0;
				while (pos < held && sorted_biased[pos] <= b)
					pos++;
				for (k = held; k > pos; k--)
					sorted_biased[k] = sorted_biased[k-1];
				sorted_biased[pos] = b;
				held++;
				if (pos > 0) begin
					d = b - sorted_biased[pos-1];
					if (d < least_gap)
						least_gap = d;
				end
				if (pos + 1 < held) begin
					d = sorted_biased[pos+1] - b;
					if (d < least_gap)
						least_gap = d;
				end
			end else begin
				r.status = bsst_pkg::STATUS_FULL;
			end
		end else if (held < 2) begin
			r.status = bsst_pkg::STATUS_TOO_FEW;
		end else begin
			r.shortest = least_gap;
			r.longest  = sorted_biased[held-1] - sorted_biased[0];
		end
		span_expect_q.insert(span_expect_q.size(), r);
	endtask

	// Sender. A transfer seen at this edge is handed to the model first; a new item is only
	// put up once the current one has gone, so a stalled payload never moves. Items go out
	// in bursts of random length separated by random gaps, some of them zero.
	always @(posedge clk) begin : drive_input
		span_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				it.op  = cmd;
				it.val = value;
				predict_span_result(it);
				accepted++;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					it = pending_q.pop_front();
					cmd      <= it.op;
					value    <= it.val;
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						case ($urandom_range(0, 9))
							0, 1, 2, 3, 4: gap_left = 0;
							5, 6, 7:       gap_left = $urandom_range(1, 3);
							8:             gap_left = $urandom_range(4, 10);
							default:       gap_left = $urandom_range(15, 30);
						endcase
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. It stalls on a pattern that is drawn afresh now and then, and once, part way
	// through the run, it holds off for a long stretch so that the result register stays full
	// and the block has to stall the sender.
	always @(posedge clk) begin : drive_stall
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (!hold_done && accepted >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 100);
			end
			mode_left--;
			case (rx_mode)
				RX_FLOW:  out_stall <= 1'b0;
				RX_HALF:  out_stall <= 1'($urandom_range(0, 1));
				RX_LIGHT: out_stall <= ($urandom_range(0, 9) == 0);
				default:  out_stall <= ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	// Result checker: every result transfer is matched against the oldest expectation.
	always @(posedge clk) begin : check_result
		span_result_t got;
		span_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, shortest_gap, longest_gap};
			if (span_expect_q.size() == 0) begin
				note_error($sformatf("unexpected result status %0d shortest %h longest %h",
					got.status, got.shortest, got.longest));
			end else begin
				want = span_expect_q.pop_front();
				if (got.status !== want.status || got.shortest !== want.shortest ||
						got.longest !== want.longest)
					note_error($sformatf(
						"expected status %0d shortest %h longest %h, got %0d %h %h",
						want.status, want.shortest, want.longest,
						got.status, got.shortest, got.longest));
			end
		end
	end

	task automatic push_item(input logic op, input logic [bsst_pkg::VAL_W-1:0] v);
		span_item_t it;
		it.op  = op;
		it.val = v;
		pending_q.insert(pending_q.size(), it);
		issued++;
	endtask

	// Waits until every queued item has been taken and every result has come back, then
	// lets the merge of a final insert run out.
	task automatic wait_idle();
		while (accepted != issued || span_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes the capacity register (with random upper bits, which the block ignores) and
	// reads it straight back. Only called while the block is idle.
	task automatic write_capacity(input logic [bsst_pkg::CAP_W-1:0] cap);
		logic [bsst_pkg::DATA_W-1:0] word;
		word = $urandom;
		word[bsst_pkg::CAP_W-1:0] = cap;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= bsst_pkg::REG_CAPACITY;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cap_shadow = cap;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		word = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (word[bsst_pkg::CAP_W-1:0] !== cap)
			note_error($sformatf("capacity read back %h, wrote %h",
				word[bsst_pkg::CAP_W-1:0], cap));
	endtask

	// Value mix: mix 0 draws over the whole range, mix 1 adds a dense cluster around zero,
	// mix 2 also adds near neighbours of the last value so that the least gap gets small.
	// Exact duplicates are kept back for the last phase, since one pins the least gap at zero.
	function automatic logic [bsst_pkg::VAL_W-1:0] draw_value(input int mix);
		logic [bsst_pkg::VAL_W-1:0] v;
		case ($urandom_range(0, mix))
			0:       v = $urandom;
			1:       v = $urandom_range(0, 1 << 22) - (1 << 21);
			default: v = $urandom_range(0, 1) ? recent_val + $urandom_range(1, 64)
			                                 : recent_val - $urandom_range(1, 64);
		endcase
		return v;
	endfunction

	task automatic run_random_phase(input int mix, input int count);
		logic [bsst_pkg::VAL_W-1:0] v;
		repeat (count) begin
			if ($urandom_range(0, 7) != 0) begin
				v = draw_value(mix);
				recent_val = v;
				push_item(bsst_pkg::CMD_ADD, v);
			end else begin
				push_item(bsst_pkg::CMD_QUERY, $urandom);
			end
		end
	endtask

	initial begin : stimulus
		int target;
		int k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no room at all, adds at the value extremes are refused and queries report
		// too few; the value field is ignored on a query, so its extremes go there too.
		write_capacity('0);
		push_item(bsst_pkg::CMD_ADD, VAL_MIN);
		push_item(bsst_pkg::CMD_ADD, VAL_MAX);
		push_item(bsst_pkg::CMD_QUERY, VAL_MIN);
		push_item(bsst_pkg::CMD_QUERY, VAL_MAX);
		wait_idle();

		// Room for one value: a single value is still too few for a query.
		write_capacity(11'd1);
		push_item(bsst_pkg::CMD_ADD, 32'd1000);
		push_item(bsst_pkg::CMD_QUERY, '0);
		push_item(bsst_pkg::CMD_ADD, 32'd5);
		wait_idle();

		// Capacity above the store depth behaves as the depth itself.
		write_capacity(11'(CAP_MAX));
		push_item(bsst_pkg::CMD_ADD, -32'sd1000);
		push_item(bsst_pkg::CMD_QUERY, '0);
		push_item(bsst_pkg::CMD_ADD, '0);
		push_item(bsst_pkg::CMD_QUERY, '1);
		push_item(bsst_pkg::CMD_ADD, 32'd1_000_000);
		push_item(bsst_pkg::CMD_QUERY, '1);
		wait_idle();

		// Capacity lowered below the number held: the values stay, new ones are refused.
		write_capacity(11'd1);
		push_item(bsst_pkg::CMD_ADD, 32'd7);
		push_item(bsst_pkg::CMD_QUERY, '0);
		wait_idle();

		// Random phases, each under a fresh capacity. Every phase boundary doubles as the
		// point where the sender waits for every outstanding result.
		for (k = 0; k < RANDOM_PHASES; k++) begin
			case ($urandom_range(0, 3))
				0:       target = held + $urandom_range(20, 150);
				1:       target = held - $urandom_range(0, held);
				2:       target = $urandom_range(STORE_DEPTH + 1, CAP_MAX);
				default: target = held + $urandom_range(0, 8);
			endcase
			if (k == 0)
				target = held + 100;
			if (target > CAP_MAX)
				target = CAP_MAX;
			write_capacity(11'(target));
			run_random_phase((k < 2) ? 0 : (k < 4) ? 1 : 2, PHASE_ITEMS);
			wait_idle();
		end

		// Capacity exactly the store depth. A duplicate of a held value drives the least
		// gap to zero, the value extremes open the range fully, and the set is then
		// filled until adds are refused.
		write_capacity(11'(STORE_DEPTH));
		push_item(bsst_pkg::CMD_ADD, sorted_biased[0] ^ SIGN_BIT);
		push_item(bsst_pkg::CMD_QUERY, '0);
		push_item(bsst_pkg::CMD_ADD, VAL_MIN);
		push_item(bsst_pkg::CMD_ADD, VAL_MAX);
		push_item(bsst_pkg::CMD_QUERY, '0);
		run_random_phase(2, (STORE_DEPTH - held) * 8 / 7 + 40);
		push_item(bsst_pkg::CMD_QUERY, '0);
		wait_idle();

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
